// File: rtl/psps_pkg.sv
// Shared types, constants and helper functions of the photometric stereo pixel solver.
package psps_pkg;

  // Geometry of the light set and of the tables.
  localparam int MAX_LIGHTS_DEF = 8;
  localparam int LIGHTS         = 8;
  localparam int AXES           = 3;
  localparam int SUBSETS        = 256;
  localparam int BANKS          = 24;
  localparam int COEFF_WORDS    = 6144;
  localparam int LIGHT_WORDS    = 24;

  // Field widths.
  localparam int SAMP_W   = 16;
  localparam int COEF_W   = 32;
  localparam int LIGHT_W  = 16;
  localparam int ADDR_W   = 13;
  localparam int CNT_W    = 4;
  localparam int CFG_IDX_W = 1;

  // Datapath widths.
  localparam int PROD_W  = 48;
  localparam int PAIR_W  = 49;
  localparam int G_W     = 51;
  localparam int MAG_W   = 50;
  localparam int GF_W    = 35;
  localparam int NA_W    = 30;
  localparam int SQA_W   = 60;
  localparam int SQ_W    = 62;
  localparam int ROOT_W  = 31;
  localparam int YC_W    = 35;
  localparam int DOTP_W  = 51;
  localparam int DOT_W   = 53;
  localparam int ERR_W   = 25;
  localparam int ESQ_W   = 47;
  localparam int EPAIR_W = 48;
  localparam int ESUM_W  = 50;
  localparam int QUO_W   = 15;
  localparam int REM_W   = 44;
  localparam int SHIFT_W = 5;
  localparam int ALB_W   = 51;
  localparam int OUT_W   = 20;

  // Pipeline depths.
  localparam int FRONT_STAGES = 11;
  localparam int SQRT_STAGES  = 31;
  localparam int DIV_STAGES   = 15;
  localparam int LAST_STAGE   = FRONT_STAGES + SQRT_STAGES + DIV_STAGES;

  // Numeric constants.
  localparam logic [SAMP_W-1:0] NONFINITE = 16'hFFFF;
  localparam logic [ROOT_W-1:0] RHO_MIN   = 31'd268;
  localparam logic [OUT_W-1:0]  OUT_MAX20 = 20'hFFFFF;
  localparam logic signed [DOT_W-1:0] ERR_HI = 53'sd8388608;
  localparam logic signed [DOT_W-1:0] ERR_LO = -53'sd8388608;

  // Request kinds.
  typedef enum logic [1:0] {
    REQ_PIXEL = 2'd0,
    REQ_COEFF = 2'd1,
    REQ_FLAG  = 2'd2,
    REQ_LIGHT = 2'd3
  } req_type_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LIGHT_COUNT      = 1'b0,
    REG_SHADOW_THRESHOLD = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    req_type_t                 req_type;
    logic                      pixel_enabled;
    logic [SAMP_W-1:0]         intensity_0;
    logic [SAMP_W-1:0]         intensity_1;
    logic [SAMP_W-1:0]         intensity_2;
    logic [SAMP_W-1:0]         intensity_3;
    logic [SAMP_W-1:0]         intensity_4;
    logic [SAMP_W-1:0]         intensity_5;
    logic [SAMP_W-1:0]         intensity_6;
    logic [SAMP_W-1:0]         intensity_7;
    logic [ADDR_W-1:0]         load_address;
    logic signed [COEF_W-1:0]  load_value;
  } in_t;

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic [OUT_W-1:0]   albedo;
    logic [OUT_W-1:0]   fit_residual;
    logic               pixel_valid;
  } out_t;

  // Table write request handed to the table block.
  typedef struct packed {
    logic              valid;
    req_type_t         kind;
    logic [ADDR_W-1:0] addr;
    logic [COEF_W-1:0] value;
  } load_t;

  // Per-pixel control that travels the whole pipeline.
  typedef struct packed {
    logic               valid;
    logic               ok;
    logic [CNT_W-1:0]   count;
    logic [LIGHTS-1:0]  mask;
    logic [AXES-1:0]    neg;
    logic [SHIFT_W-1:0] shift;
  } meta_t;

  typedef logic [BANKS-1:0][COEF_W-1:0]        coef_vec_t;
  typedef logic [LIGHT_WORDS-1:0][LIGHT_W-1:0] light_vec_t;
  typedef logic [LIGHTS-1:0][SAMP_W-1:0]       samp_vec_t;

  typedef struct packed {
    logic [SQ_W-1:0]   e;
    logic [SQ_W-1:0]   q;
    logic [YC_W-1:0]   yc;
    logic [CNT_W-1:0]  c;
    logic [ROOT_W-1:0] y;
  } sqrt_stage_t;

  typedef struct packed {
    logic [AXES-1:0][REM_W-1:0] rem;
    logic [ROOT_W-1:0]          den;
    logic [AXES-1:0][QUO_W-1:0] quo;
  } div_stage_t;

  // Right shift that brings the largest magnitude below 2^NA_W.
  function automatic logic [SHIFT_W-1:0] norm_shift(input logic [MAG_W-1:0] v);
    logic [SHIFT_W-1:0] s;
    s = '0;
    for (int b = NA_W; b < MAG_W; b++) begin
      if (v[b]) begin
        s = SHIFT_W'(b - NA_W + 1);
      end
    end
    return s;
  endfunction

endpackage

// File: rtl/psps_tables.sv
// Coefficient banks, subset flags and light table with registered lookup.
module psps_tables (
  input  logic                   clk,
  input  logic                   rst_n,
  input  psps_pkg::load_t        ld,
  input  logic                   rd_en,
  input  logic [psps_pkg::LIGHTS-1:0] rd_mask,
  output psps_pkg::coef_vec_t    coef_q,
  output logic                   usable_q,
  output psps_pkg::light_vec_t   lights
);

  localparam logic [19:0] RECIP3 = 20'd683;

  logic [9:0]                     addr_hi;
  logic [19:0]                    quot_prod;
  logic [8:0]                     subset_full;
  logic [psps_pkg::ADDR_W-1:0]    bank_rem;
  logic [4:0]                     bank_sel;
  logic                           coef_we;
  logic [psps_pkg::COEF_W-1:0]    rd_r [psps_pkg::BANKS];
  logic [psps_pkg::SUBSETS-1:0]   flag_r;
  psps_pkg::light_vec_t           light_r;

  // Split a coefficient address into subset (address / 24) and bank (address % 24).
  always_comb begin
    addr_hi     = ld.addr[psps_pkg::ADDR_W-1:3];
    quot_prod   = 20'(addr_hi) * RECIP3;
    subset_full = quot_prod[19:11];
    bank_rem    = ld.addr - 13'(subset_full) * 13'(psps_pkg::BANKS);
    bank_sel    = bank_rem[4:0];
    coef_we     = ld.valid && (ld.kind == psps_pkg::REQ_COEFF) &&
                  (ld.addr < 13'(psps_pkg::COEFF_WORDS));
  end

  // One bank per coefficient slot of a subset, all read at the subset index.
  for (genvar b = 0; b < psps_pkg::BANKS; b++) begin : g_bank
    logic [psps_pkg::COEF_W-1:0] mem [psps_pkg::SUBSETS];

    always_ff @(posedge clk) begin
      if (coef_we && (bank_sel == 5'(b))) begin
        mem[subset_full[7:0]] <= ld.value;
      end
      if (rd_en) begin
        rd_r[b] <= mem[rd_mask];
      end
    end
  end

  always_comb begin
    for (int b = 0; b < psps_pkg::BANKS; b++) begin
      coef_q[b] = rd_r[b];
    end
  end

  // Subset usable flags, cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r <= '0;
    end else if (ld.valid && (ld.kind == psps_pkg::REQ_FLAG) &&
                 (ld.addr < 13'(psps_pkg::SUBSETS))) begin
      flag_r[ld.addr[7:0]] <= ld.value[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      usable_q <= flag_r[rd_mask];
    end
  end

  // Light direction components.
  always_ff @(posedge clk) begin
    if (ld.valid && (ld.kind == psps_pkg::REQ_LIGHT) &&
        (ld.addr < 13'(psps_pkg::LIGHT_WORDS))) begin
      light_r[ld.addr[4:0]] <= ld.value[psps_pkg::LIGHT_W-1:0];
    end
  end

  assign lights = light_r;

endmodule

// File: rtl/psps_sqrt_pipe.sv
// Pipelined root: largest y with c*y*y <= e, one result bit per stage.
module psps_sqrt_pipe (
  input  logic                        clk,
  input  logic                        en,
  input  logic [psps_pkg::SQ_W-1:0]   rad,
  input  logic [psps_pkg::CNT_W-1:0]  cnt,
  output logic [psps_pkg::ROOT_W-1:0] root
);

  localparam int N  = psps_pkg::SQRT_STAGES;
  localparam int TW = psps_pkg::SQ_W + 6;

  psps_pkg::sqrt_stage_t st_r [1:N];
  psps_pkg::sqrt_stage_t st_in;

  always_comb begin
    st_in    = '0;
    st_in.e  = rad;
    st_in.c  = cnt;
  end

  for (genvar j = 1; j <= N; j++) begin : g_stage
    localparam int K = N - j;
    psps_pkg::sqrt_stage_t prev;
    psps_pkg::sqrt_stage_t st_nxt;
    logic [TW-1:0]         trial;

    if (j == 1) begin : g_first
      assign prev = st_in;
    end else begin : g_next
      assign prev = st_r[j-1];
    end

    // Try setting bit K: c*(y+2^K)^2 = c*y^2 + c*y*2^(K+1) + c*2^(2K).
    always_comb begin
      trial  = TW'(prev.q) + (TW'(prev.yc) << (K + 1)) + (TW'(prev.c) << (2 * K));
      st_nxt = prev;
      if (trial <= TW'(prev.e)) begin
        st_nxt.q  = psps_pkg::SQ_W'(trial);
        st_nxt.yc = prev.yc + (psps_pkg::YC_W'(prev.c) << K);
        st_nxt.y  = prev.y | (psps_pkg::ROOT_W'(1) << K);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[j] <= st_nxt;
      end
    end
  end

  assign root = st_r[N].y;

endmodule

// File: rtl/psps_div_pipe.sv
// Three-lane restoring divider for the normal components, one quotient bit per stage.
module psps_div_pipe (
  input  logic                                            clk,
  input  logic                                            en,
  input  logic [psps_pkg::AXES-1:0][psps_pkg::NA_W-1:0]   num,
  input  logic [psps_pkg::ROOT_W-1:0]                     den,
  output logic [psps_pkg::AXES-1:0][psps_pkg::QUO_W-1:0]  quo
);

  localparam int N  = psps_pkg::DIV_STAGES;
  localparam int CW = psps_pkg::REM_W + 2;

  psps_pkg::div_stage_t st_r [1:N];
  psps_pkg::div_stage_t st_in;

  // The dividend is the magnitude scaled up to Q1.14.
  always_comb begin
    st_in     = '0;
    st_in.den = den;
    for (int a = 0; a < psps_pkg::AXES; a++) begin
      st_in.rem[a] = {num[a], 14'b0};
    end
  end

  for (genvar j = 1; j <= N; j++) begin : g_stage
    localparam int K = N - j;
    psps_pkg::div_stage_t prev;
    psps_pkg::div_stage_t st_nxt;
    logic [CW-1:0]        sub;

    if (j == 1) begin : g_first
      assign prev = st_in;
    end else begin : g_next
      assign prev = st_r[j-1];
    end

    always_comb begin
      st_nxt = prev;
      sub    = CW'(prev.den) << K;
      for (int a = 0; a < psps_pkg::AXES; a++) begin
        if (CW'(prev.rem[a]) >= sub) begin
          st_nxt.rem[a] = prev.rem[a] - psps_pkg::REM_W'(sub);
          st_nxt.quo[a] = prev.quo[a] | (psps_pkg::QUO_W'(1) << K);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[j] <= st_nxt;
      end
    end
  end

  assign quo = st_r[N].quo;

endmodule

// File: rtl/photometric_stereo_pixel_solve.sv
// Top level of the per-pixel photometric stereo least-squares solver.
//
//  Channel | Ports                          | Moves
//  --------+--------------------------------+-------------------------------------
//  input   | in_valid, in_stall, in_data    | pixel or table load request
//  result  | out_valid, out_stall, out_data | normal, albedo, residual per pixel
//  config  | cfg_we, cfg_addr, cfg_wdata    | light count, shadow threshold
//
// One request per cycle is taken while in_stall is low; a pixel result passes the pipeline
// registers into the output queue and is presented from the next cycle.
// The depth is 11 front stages plus the 31-stage root units and the 15-stage divider.
// Load requests write their table at acceptance and give no result.
// Reset clears the subset flags and the pipeline valid bits.
// The pipeline halts only while both entries of the two-deep output queue are full.
module photometric_stereo_pixel_solve #(
  parameter int MAX_LIGHTS = psps_pkg::MAX_LIGHTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  psps_pkg::in_t                  in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output psps_pkg::out_t                 out_data,
  input  logic                           cfg_we,
  input  logic [psps_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [15:0]                    cfg_wdata
);

  localparam int L  = psps_pkg::LIGHTS;
  localparam int AX = psps_pkg::AXES;
  localparam int SQ_OUT = psps_pkg::FRONT_STAGES + psps_pkg::SQRT_STAGES;
  localparam int LAST   = psps_pkg::LAST_STAGE;

  // Configuration registers.
  logic [psps_pkg::CNT_W-1:0]  light_count_r;
  logic [psps_pkg::SAMP_W-1:0] shadow_thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_count_r <= 4'd8;
      shadow_thr_r  <= '0;
    end else if (cfg_we) begin
      unique case (psps_pkg::cfg_reg_t'(cfg_addr))
        psps_pkg::REG_LIGHT_COUNT:      light_count_r <= cfg_wdata[3:0];
        psps_pkg::REG_SHADOW_THRESHOLD: shadow_thr_r  <= cfg_wdata;
      endcase
    end
  end

  // Pipeline advance and output queue state.
  logic       en;
  logic [1:0] cnt_r;
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  psps_pkg::out_t fifo_r [2];

  assign en       = (cnt_r != 2'd2);
  assign in_stall = !en;

  // Stage 0: lit mask and count from the incoming request.
  psps_pkg::samp_vec_t        samp_in;
  logic [psps_pkg::CNT_W-1:0] n_eff;
  logic [L-1:0]               lit;
  logic [psps_pkg::CNT_W-1:0] lit_cnt;
  logic                       is_pixel;
  psps_pkg::load_t            ld;

  always_comb begin
    samp_in = {in_data.intensity_7, in_data.intensity_6, in_data.intensity_5,
               in_data.intensity_4, in_data.intensity_3, in_data.intensity_2,
               in_data.intensity_1, in_data.intensity_0};
    n_eff   = (light_count_r > psps_pkg::CNT_W'(MAX_LIGHTS)) ?
              psps_pkg::CNT_W'(MAX_LIGHTS) : light_count_r;
    lit_cnt = '0;
    for (int i = 0; i < L; i++) begin
      lit[i]  = (psps_pkg::CNT_W'(i) < n_eff) && (samp_in[i] != psps_pkg::NONFINITE) &&
                (samp_in[i] > shadow_thr_r);
      lit_cnt = lit_cnt + psps_pkg::CNT_W'(lit[i]);
    end
    is_pixel  = (in_data.req_type == psps_pkg::REQ_PIXEL);
    ld.valid  = in_valid && en && !is_pixel;
    ld.kind   = in_data.req_type;
    ld.addr   = in_data.load_address;
    ld.value  = in_data.load_value;
  end

  psps_pkg::coef_vec_t  coef_q;
  logic                 usable_q;
  psps_pkg::light_vec_t lights;

  psps_tables u_tables (
    .clk      (clk),
    .rst_n    (rst_n),
    .ld       (ld),
    .rd_en    (en),
    .rd_mask  (lit),
    .coef_q   (coef_q),
    .usable_q (usable_q),
    .lights   (lights)
  );

  // Control that travels with each pixel.
  psps_pkg::meta_t meta_r   [1:LAST];
  psps_pkg::meta_t meta_nxt [1:LAST];

  // Datapath stage registers.
  psps_pkg::samp_vec_t  samp_r  [1:7];
  psps_pkg::light_vec_t light_r [1:5];
  logic signed [psps_pkg::PROD_W-1:0] prod2_r  [AX][L];
  logic signed [psps_pkg::PAIR_W-1:0] pair3_r  [AX][4];
  logic signed [psps_pkg::G_W-1:0]    g4_r     [AX];
  logic [psps_pkg::MAG_W-1:0]         mag5_r   [AX];
  logic signed [psps_pkg::GF_W-1:0]   gf5_r    [AX];
  logic [psps_pkg::MAG_W-1:0]         mag6_r   [AX];
  logic signed [psps_pkg::DOTP_W-1:0] dotp6_r  [L][AX];
  logic signed [psps_pkg::DOT_W-1:0]  dot7_r   [L];
  logic signed [psps_pkg::ERR_W-1:0]  err8_r   [L];
  logic [psps_pkg::SQA_W-1:0]         sqa8_r   [AX];
  logic [psps_pkg::ESQ_W-1:0]         esq9_r   [L];
  logic [psps_pkg::SQ_W-1:0]          sq9_r;
  logic [psps_pkg::EPAIR_W-1:0]       epair10_r [4];
  logic [psps_pkg::SQ_W-1:0]          sq10_r;
  logic [psps_pkg::ESUM_W-1:0]        esum11_r;
  logic [psps_pkg::SQ_W-1:0]          sq11_r;
  logic [AX-1:0][psps_pkg::NA_W-1:0]  a_r     [7:SQ_OUT];
  logic [psps_pkg::ROOT_W-1:0]        rho_r   [SQ_OUT+1:LAST];
  logic [psps_pkg::ROOT_W-1:0]        rms_r   [SQ_OUT+1:LAST];

  // Control delay line, with fields filled in where they become known.
  always_comb begin
    meta_nxt[1].valid = in_valid && is_pixel;
    meta_nxt[1].ok    = in_data.pixel_enabled && (lit_cnt != '0);
    meta_nxt[1].count = lit_cnt;
    meta_nxt[1].mask  = lit;
    meta_nxt[1].neg   = '0;
    meta_nxt[1].shift = '0;
    for (int k = 2; k <= LAST; k++) begin
      meta_nxt[k] = meta_r[k-1];
    end
    meta_nxt[2].ok = meta_r[1].ok && usable_q;
    for (int a = 0; a < AX; a++) begin
      meta_nxt[5].neg[a] = g4_r[a][psps_pkg::G_W-1];
    end
    meta_nxt[6].shift = psps_pkg::norm_shift(mag5_r[0] | mag5_r[1] | mag5_r[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= LAST; k++) begin
        meta_r[k].valid <= 1'b0;
      end
    end else if (en) begin
      for (int k = 1; k <= LAST; k++) begin
        meta_r[k] <= meta_nxt[k];
      end
    end
  end

  // Stage 1: lit samples only, light snapshot; later stages carry both along.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < L; i++) begin
        samp_r[1][i] <= lit[i] ? samp_in[i] : '0;
      end
      light_r[1] <= lights;
      for (int k = 2; k <= 7; k++) begin
        samp_r[k] <= samp_r[k-1];
      end
      for (int k = 2; k <= 5; k++) begin
        light_r[k] <= light_r[k-1];
      end
    end
  end

  // Stages 2 to 4: g = coefficients times samples, summed over a two-level tree.
  logic signed [psps_pkg::PROD_W-1:0] prod_c [AX][L];

  always_comb begin
    for (int a = 0; a < AX; a++) begin
      for (int i = 0; i < L; i++) begin
        prod_c[a][i] = $signed(coef_q[a*L+i]) * $signed({1'b0, samp_r[1][i]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < AX; a++) begin
        for (int i = 0; i < L; i++) begin
          prod2_r[a][i] <= prod_c[a][i];
        end
        for (int p = 0; p < 4; p++) begin
          pair3_r[a][p] <= prod2_r[a][2*p] + prod2_r[a][2*p+1];
        end
        g4_r[a] <= pair3_r[a][0] + pair3_r[a][1] + pair3_r[a][2] + pair3_r[a][3];
      end
    end
  end

  // Stage 5: magnitudes for the norm and g floored to Q.12 for the residual.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < AX; a++) begin
        mag5_r[a] <= g4_r[a][psps_pkg::G_W-1] ? psps_pkg::MAG_W'(-g4_r[a]) :
                                                psps_pkg::MAG_W'(g4_r[a]);
        gf5_r[a]  <= g4_r[a][psps_pkg::G_W-1:16];
      end
    end
  end

  // Stages 6 to 11 of the residual: light . g, error, square and sum.
  logic signed [psps_pkg::DOTP_W-1:0] dotp_c [L][AX];
  logic signed [psps_pkg::DOT_W-1:0]  dot_c  [L];
  logic signed [psps_pkg::DOT_W-1:0]  diff_c [L];
  logic signed [psps_pkg::DOT_W-1:0]  clmp_c [L];
  logic signed [2*psps_pkg::ERR_W-1:0] esq_c [L];

  always_comb begin
    for (int i = 0; i < L; i++) begin
      for (int a = 0; a < AX; a++) begin
        dotp_c[i][a] = $signed(light_r[5][i*AX+a]) * gf5_r[a];
      end
      dot_c[i]  = dotp6_r[i][0] + dotp6_r[i][1] + dotp6_r[i][2];
      diff_c[i] = (dot7_r[i] >>> 14) - $signed({1'b0, samp_r[7][i]});
      if (diff_c[i] > psps_pkg::ERR_HI) begin
        clmp_c[i] = psps_pkg::ERR_HI;
      end else if (diff_c[i] < psps_pkg::ERR_LO) begin
        clmp_c[i] = psps_pkg::ERR_LO;
      end else begin
        clmp_c[i] = diff_c[i];
      end
      esq_c[i] = err8_r[i] * err8_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < L; i++) begin
        for (int a = 0; a < AX; a++) begin
          dotp6_r[i][a] <= dotp_c[i][a];
        end
        dot7_r[i] <= dot_c[i];
        err8_r[i] <= clmp_c[i][psps_pkg::ERR_W-1:0];
        esq9_r[i] <= meta_r[8].mask[i] ? esq_c[i][psps_pkg::ESQ_W-1:0] : '0;
      end
      for (int p = 0; p < 4; p++) begin
        epair10_r[p] <= psps_pkg::EPAIR_W'(esq9_r[2*p]) + psps_pkg::EPAIR_W'(esq9_r[2*p+1]);
      end
      esum11_r <= psps_pkg::ESUM_W'(epair10_r[0]) + psps_pkg::ESUM_W'(epair10_r[1]) +
                  psps_pkg::ESUM_W'(epair10_r[2]) + psps_pkg::ESUM_W'(epair10_r[3]);
    end
  end

  // Stages 6 to 11 of the norm: hold, shift down, square and sum.
  logic [psps_pkg::SQA_W-1:0] sqa_c [AX];

  always_comb begin
    for (int a = 0; a < AX; a++) begin
      sqa_c[a] = a_r[7][a] * a_r[7][a];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < AX; a++) begin
        mag6_r[a]  <= mag5_r[a];
        a_r[7][a]  <= psps_pkg::NA_W'(mag6_r[a] >> meta_r[6].shift);
        sqa8_r[a]  <= sqa_c[a];
      end
      for (int k = 8; k <= SQ_OUT; k++) begin
        a_r[k] <= a_r[k-1];
      end
      sq9_r  <= psps_pkg::SQ_W'(sqa8_r[0]) + psps_pkg::SQ_W'(sqa8_r[1]) +
                psps_pkg::SQ_W'(sqa8_r[2]);
      sq10_r <= sq9_r;
      sq11_r <= sq10_r;
    end
  end

  // Root units: norm of the shifted g, and residual RMS as sqrt(sum / count).
  logic [psps_pkg::ROOT_W-1:0] rho_q;
  logic [psps_pkg::ROOT_W-1:0] rms_q;

  psps_sqrt_pipe u_sqrt_norm (
    .clk  (clk),
    .en   (en),
    .rad  (sq11_r),
    .cnt  (psps_pkg::CNT_W'(1)),
    .root (rho_q)
  );

  psps_sqrt_pipe u_sqrt_resid (
    .clk  (clk),
    .en   (en),
    .rad  (psps_pkg::SQ_W'(esum11_r)),
    .cnt  (meta_r[psps_pkg::FRONT_STAGES].count),
    .root (rms_q)
  );

  // Normal components: shifted magnitude in Q1.14 over the norm.
  logic [AX-1:0][psps_pkg::QUO_W-1:0] quo_q;

  psps_div_pipe u_div (
    .clk (clk),
    .en  (en),
    .num (a_r[SQ_OUT]),
    .den (rho_q),
    .quo (quo_q)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      rho_r[SQ_OUT+1] <= rho_q;
      rms_r[SQ_OUT+1] <= rms_q;
      for (int k = SQ_OUT + 2; k <= LAST; k++) begin
        rho_r[k] <= rho_r[k-1];
        rms_r[k] <= rms_r[k-1];
      end
    end
  end

  // Final formatting: signs, saturation and the invalid-pixel checks.
  psps_pkg::meta_t             fin;
  logic [psps_pkg::ROOT_W-1:0] rho_f;
  logic [psps_pkg::ALB_W-1:0]  alb_wide;
  logic [psps_pkg::ALB_W-17:0] alb_q12;
  logic signed [15:0]          nrm [AX];
  logic                        solved;
  psps_pkg::out_t              res;

  always_comb begin
    fin      = meta_r[LAST];
    rho_f    = rho_r[LAST];
    alb_wide = psps_pkg::ALB_W'(rho_f) << fin.shift;
    alb_q12  = alb_wide[psps_pkg::ALB_W-1:16];
    for (int a = 0; a < AX; a++) begin
      nrm[a] = fin.neg[a] ? -$signed({1'b0, quo_q[a]}) : $signed({1'b0, quo_q[a]});
    end
    solved = fin.ok && (rho_f != '0) &&
             !((fin.shift == '0) && (rho_f <= psps_pkg::RHO_MIN)) &&
             !fin.neg[2] && (quo_q[2] != '0);
    res = '0;
    if (solved) begin
      res.normal_x     = nrm[0];
      res.normal_y     = nrm[1];
      res.normal_z     = nrm[2];
      res.albedo       = (alb_q12 > (psps_pkg::ALB_W - 16)'(psps_pkg::OUT_MAX20)) ?
                         psps_pkg::OUT_MAX20 : alb_q12[psps_pkg::OUT_W-1:0];
      res.fit_residual = (rms_r[LAST] > psps_pkg::ROOT_W'(psps_pkg::OUT_MAX20)) ?
                         psps_pkg::OUT_MAX20 : rms_r[LAST][psps_pkg::OUT_W-1:0];
      res.pixel_valid  = 1'b1;
    end
  end

  // Two-entry output queue so that a waiting result does not hold up the pipeline.
  logic push;
  logic pop;

  assign push = en && meta_r[LAST].valid;
  assign pop  = (cnt_r != 2'd0) && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= res;
    end
  end

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = fifo_r[rd_ptr_r];

endmodule

// File: tb/sv/tb_photometric_stereo_pixel_solve.sv
// Self-checking testbench of the photometric stereo per-pixel solver.
module tb_photometric_stereo_pixel_solve;

  typedef logic [7:0][15:0] samples_t;

  // One row of the directed table; want is only used where typed is set.
  typedef struct {
    psps_pkg::in_t  req;
    bit             typed;
    psps_pkg::out_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  psps_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  psps_pkg::out_t out_data;
  logic cfg_we = 1'b0;
  logic [psps_pkg::CFG_IDX_W-1:0] cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;

  // Shadow copy of the block's tables and registers.
  logic [31:0] coeff_mem [psps_pkg::COEFF_WORDS];
  bit coeff_known [psps_pkg::COEFF_WORDS];
  bit subset_ok [psps_pkg::SUBSETS];
  logic [15:0] light_mem [psps_pkg::LIGHT_WORDS];
  int unsigned lights_in_use = 8;
  int unsigned shade_level = 0;

  psps_pkg::out_t pending_solutions [$];
  stim_row_t directed_rows [$];
  int unsigned ready_masks [$];
  int errors = 0;
  int pixels_sent = 0;
  int loads_sent = 0;
  int solved_seen = 0;
  bit drive_quiet = 1'b0;

  photometric_stereo_pixel_solve dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic samples_t samples_of(psps_pkg::in_t p);
    return {p.intensity_7, p.intensity_6, p.intensity_5, p.intensity_4,
            p.intensity_3, p.intensity_2, p.intensity_1, p.intensity_0};
  endfunction

  function automatic psps_pkg::in_t pixel_req(bit en, samples_t s);
    psps_pkg::in_t p;
    p = '0;
    p.req_type = psps_pkg::REQ_PIXEL;
    p.pixel_enabled = en;
    {p.intensity_7, p.intensity_6, p.intensity_5, p.intensity_4,
     p.intensity_3, p.intensity_2, p.intensity_1, p.intensity_0} = s;
    return p;
  endfunction

  function automatic psps_pkg::in_t load_req(psps_pkg::req_type_t k, int unsigned addr,
                                             logic [31:0] v);
    psps_pkg::in_t p;
    p = '0;
    p.req_type = k;
    p.load_address = addr[psps_pkg::ADDR_W-1:0];
    p.load_value = v;
    return p;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res = 0;
    longint unsigned b = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Least-squares solve of one pixel against the shadow tables.
  function automatic psps_pkg::out_t solve_pixel(psps_pkg::in_t p);
    psps_pkg::out_t o;
    samples_t s;
    int unsigned n, mask, count, sh;
    longint g [3];
    longint unsigned mag [3];
    longint unsigned top, sq, rho, alb, esum, rms, a;
    longint q, dot, d;
    o = '0;
    s = samples_of(p);
    mask = 0;
    count = 0;
    sh = 0;
    esum = 0;
    if (!p.pixel_enabled) return o;
    n = (lights_in_use > 8) ? 8 : lights_in_use;
    for (int i = 0; i < 8; i++) begin
      if (i < n && s[i] != psps_pkg::NONFINITE && s[i] > shade_level) begin
        mask |= 1 << i;
        count++;
      end
    end
    if (count == 0 || !subset_ok[mask]) return o;
    for (int r = 0; r < 3; r++) begin
      g[r] = 0;
      for (int i = 0; i < 8; i++)
        if (mask[i])
          g[r] += longint'($signed(coeff_mem[mask*24 + r*8 + i])) * longint'(s[i]);
      mag[r] = (g[r] < 0) ? longint'(-g[r]) : g[r];
    end
    top = mag[0];
    if (mag[1] > top) top = mag[1];
    if (mag[2] > top) top = mag[2];
    while ((top >> sh) >= (64'd1 << 30)) sh++;
    sq = 0;
    for (int r = 0; r < 3; r++) begin
      a = mag[r] >> sh;
      sq += a * a;
    end
    rho = int_sqrt(sq);
    if (rho == 0 || (sh == 0 && rho <= psps_pkg::RHO_MIN)) return o;
    q = longint'(((mag[2] >> sh) << 14) / rho);
    if (g[2] < 0 || q == 0) return o;
    o.normal_z = 16'(q);
    q = longint'(((mag[0] >> sh) << 14) / rho);
    o.normal_x = 16'((g[0] < 0) ? -q : q);
    q = longint'(((mag[1] >> sh) << 14) / rho);
    o.normal_y = 16'((g[1] < 0) ? -q : q);
    alb = (rho << sh) >> 16;
    o.albedo = (alb > psps_pkg::OUT_MAX20) ? psps_pkg::OUT_MAX20 : alb[psps_pkg::OUT_W-1:0];
    // Residual of the re-lit surface against each lit sample.
    for (int i = 0; i < 8; i++) begin
      if (mask[i]) begin
        dot = 0;
        for (int r = 0; r < 3; r++)
          dot += longint'($signed(light_mem[i*3 + r])) * (g[r] >>> 16);
        d = (dot >>> 14) - longint'(s[i]);
        if (d > 8388608) d = 8388608;
        if (d < -8388608) d = -8388608;
        esum += longint'(d * d);
      end
    end
    rms = int_sqrt(esum / count);
    o.fit_residual = (rms > psps_pkg::OUT_MAX20) ? psps_pkg::OUT_MAX20
                                                 : rms[psps_pkg::OUT_W-1:0];
    o.pixel_valid = 1'b1;
    return o;
  endfunction

  // Applies an accepted request to the shadow tables or queues its solution.
  task automatic note_accepted(psps_pkg::in_t p, bit typed, psps_pkg::out_t want);
    case (p.req_type)
      psps_pkg::REQ_PIXEL: begin
        pending_solutions.insert(pending_solutions.size(), typed ? want : solve_pixel(p));
        pixels_sent++;
      end
      psps_pkg::REQ_COEFF: begin
        if (p.load_address < psps_pkg::COEFF_WORDS) begin
          coeff_mem[p.load_address] = p.load_value;
          coeff_known[p.load_address] = 1'b1;
        end
        loads_sent++;
      end
      psps_pkg::REQ_FLAG: begin
        if (p.load_address < psps_pkg::SUBSETS) subset_ok[p.load_address] = p.load_value[0];
        loads_sent++;
      end
      default: begin
        if (p.load_address < psps_pkg::LIGHT_WORDS)
          light_mem[p.load_address] = p.load_value[15:0];
        loads_sent++;
      end
    endcase
  endtask

  // Presents one request and holds it until the block takes it.
  task automatic send(psps_pkg::in_t p, bit typed = 1'b0, psps_pkg::out_t want = '0);
    if (!drive_quiet && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    note_accepted(p, typed, want);
  endtask

  // Adds a row to the directed table; typed rows expect an all-zero result.
  task automatic add_row(psps_pkg::in_t req, bit typed = 1'b0);
    stim_row_t row;
    row.req = req;
    row.typed = typed;
    row.want = '0;
    directed_rows.insert(directed_rows.size(), row);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_solutions.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  task automatic write_reg(psps_pkg::cfg_reg_t idx, int unsigned v);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= v[15:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == psps_pkg::REG_LIGHT_COUNT) lights_in_use = v & 4'hF;
    else shade_level = v & 16'hFFFF;
  endtask

  // Fills one subset's pseudoinverse; kind 0 plausible, 1 negative z, 2 all zero.
  task automatic fill_subset(int unsigned m, int kind);
    logic [31:0] v;
    for (int w = 0; w < 24; w++) begin
      if (kind == 2) v = '0;
      else if (w >= 16) v = (kind == 1) ? -$urandom_range(8192, 65536)
                                        : $urandom_range(8192, 65536);
      else v = int'($urandom_range(0, 32768)) - 16384;
      send(load_req(psps_pkg::REQ_COEFF, m*24 + w, v));
    end
    send(load_req(psps_pkg::REQ_FLAG, m, 32'd1));
    ready_masks.insert(ready_masks.size(), m);
  endtask

  // Builds a pixel whose lit set is the given mask under the current registers.
  function automatic psps_pkg::in_t pixel_for(int unsigned m, bit en);
    samples_t s;
    for (int i = 0; i < 8; i++) begin
      if (m[i]) s[i] = $urandom_range(shade_level + 1, 65534);
      else if (i < lights_in_use && $urandom_range(0, 3) == 0) s[i] = psps_pkg::NONFINITE;
      else if (i < lights_in_use) s[i] = $urandom_range(0, shade_level);
      else s[i] = $urandom_range(0, 65535);
    end
    return pixel_req(en, s);
  endfunction

  function automatic bit subset_complete(int unsigned m);
    for (int w = 0; w < 24; w++)
      if (!coeff_known[m*24 + w]) return 1'b0;
    return 1'b1;
  endfunction

  // Result checking against the oldest outstanding solution.
  always @(posedge clk) begin
    psps_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_solutions.size() == 0) begin
        $error("unexpected result %h", out_data);
        errors++;
      end else begin
        want = pending_solutions.pop_front();
        if (out_data.pixel_valid) solved_seen++;
        if (out_data.normal_x !== want.normal_x) begin
          $error("normal_x: expected %0d, got %0d", want.normal_x, out_data.normal_x);
          errors++;
        end
        if (out_data.normal_y !== want.normal_y) begin
          $error("normal_y: expected %0d, got %0d", want.normal_y, out_data.normal_y);
          errors++;
        end
        if (out_data.normal_z !== want.normal_z) begin
          $error("normal_z: expected %0d, got %0d", want.normal_z, out_data.normal_z);
          errors++;
        end
        if (out_data.albedo !== want.albedo) begin
          $error("albedo: expected %0d, got %0d", want.albedo, out_data.albedo);
          errors++;
        end
        if (out_data.fit_residual !== want.fit_residual) begin
          $error("fit_residual: expected %0d, got %0d", want.fit_residual,
                 out_data.fit_residual);
          errors++;
        end
        if (out_data.pixel_valid !== want.pixel_valid) begin
          $error("pixel_valid: expected %0d, got %0d", want.pixel_valid,
                 out_data.pixel_valid);
          errors++;
        end
      end
    end
  end

  // Receiver back-pressure in random bursts.
  initial begin
    forever begin
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      if (!drive_quiet) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // Watchdog.
  initial begin
    #3000000;
    $display("tb_photometric_stereo_pixel_solve NOT OK");
    $finish;
  end

  initial begin
    int unsigned phase_lc [6] = '{3, 15, 5, 8, 6, 8};
    int unsigned phase_th [6] = '{1000, 0, 65534, 20000, 43690, 0};
    int unsigned m, a, pick;
    logic [31:0] v;
    psps_pkg::in_t p;
    samples_t s;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Light directions and a handful of solvable subsets.
    for (int w = 0; w < psps_pkg::LIGHT_WORDS; w++)
      send(load_req(psps_pkg::REQ_LIGHT, w,
                    (w % 3 == 2) ? $urandom_range(8192, 16384)
                                 : int'($urandom_range(0, 16384)) - 8192));
    fill_subset(8'hFF, 0);
    fill_subset(8'h07, 0);
    fill_subset(8'h03, 0);
    fill_subset(8'h3F, 0);
    fill_subset(8'h1F, 0);
    fill_subset(8'h0F, 1);
    fill_subset(8'h05, 2);
    // Random subsets stay clear of those whose directed rows expect no solution.
    repeat (4) begin
      do m = $urandom_range(1, 255);
      while (m == 8'h01 || m == 8'h05 || m == 8'h0F);
      fill_subset(m, 0);
    end

    // Directed table: extremes, dead pixels, out-of-range loads.
    add_row(pixel_req(1'b0, {8{16'hFFFE}}), 1'b1);
    add_row(pixel_req(1'b1, {8{psps_pkg::NONFINITE}}), 1'b1);
    add_row(pixel_req(1'b1, '0), 1'b1);
    add_row(pixel_req(1'b1, {112'd0, 16'd4096}), 1'b1);
    add_row(pixel_req(1'b1, {8{16'hFFFE}}));
    add_row(pixel_req(1'b1, {8{16'h0001}}));
    add_row(pixel_req(1'b1, {64'd0, {4{16'd30000}}}), 1'b1);
    add_row(pixel_req(1'b1, {80'd0, 16'd9000, 16'd0, 16'd9000}), 1'b1);
    add_row(load_req(psps_pkg::REQ_COEFF, 6144, 32'h7FFF_FFFF));
    add_row(load_req(psps_pkg::REQ_COEFF, 8191, 32'hFFFF_FFFF));
    add_row(load_req(psps_pkg::REQ_FLAG, 8191, 32'd1));
    add_row(load_req(psps_pkg::REQ_LIGHT, 24, 32'hFFFF_FFFF));
    add_row(load_req(psps_pkg::REQ_LIGHT, 8191, 32'h8000_0000));
    add_row(load_req(psps_pkg::REQ_COEFF, 255*24 + 16, 32'h8000_0000));
    add_row(pixel_req(1'b1, {8{16'hFFFE}}));
    add_row(load_req(psps_pkg::REQ_COEFF, 255*24 + 16, 32'h7FFF_FFFF));
    add_row(pixel_req(1'b1, {8{16'hFFFE}}));
    add_row(load_req(psps_pkg::REQ_FLAG, 7, 32'd0));
    add_row(pixel_req(1'b1, {80'd0, {3{16'd30000}}}), 1'b1);
    add_row(load_req(psps_pkg::REQ_FLAG, 7, 32'd1));
    add_row(pixel_req(1'b1, {80'd0, {3{16'd30000}}}));
    foreach (directed_rows[k])
      send(directed_rows[k].req, directed_rows[k].typed, directed_rows[k].want);
    settle();

    // Random phases, each under its own register setting.
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(psps_pkg::REG_LIGHT_COUNT, phase_lc[ph]);
      write_reg(psps_pkg::REG_SHADOW_THRESHOLD, phase_th[ph]);
      drive_quiet = (ph == 5);
      for (int it = 0; it < 265; it++) begin
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
          m = ready_masks[$urandom_range(0, ready_masks.size() - 1)];
          if (shade_level < 65534 && (m >> ((lights_in_use > 8) ? 8 : lights_in_use)) == 0)
            p = pixel_for(m, $urandom_range(0, 19) != 0);
          else
            p = pixel_for($urandom_range(0, 255) & ((1 << lights_in_use) - 1), 1'b1);
        end else if (pick < 85) begin
          for (int i = 0; i < 8; i++) s[i] = $urandom_range(0, 65535);
          p = pixel_req($urandom_range(0, 1), s);
        end else begin
          v = $urandom();
          case ($urandom_range(0, 2))
            0: begin
              a = ($urandom_range(0, 9) == 0) ? $urandom_range(6144, 8191)
                                              : $urandom_range(0, 6143);
              if ($urandom_range(0, 1) == 0) v = int'($urandom_range(0, 65536)) - 32768;
              p = load_req(psps_pkg::REQ_COEFF, a, v);
            end
            1: begin
              a = ($urandom_range(0, 9) == 0) ? $urandom_range(256, 8191)
                                              : $urandom_range(0, 255);
              if (a < psps_pkg::SUBSETS && !subset_complete(a)) v[0] = 1'b0;
              p = load_req(psps_pkg::REQ_FLAG, a, v);
            end
            default: begin
              a = ($urandom_range(0, 9) == 0) ? $urandom_range(24, 8191)
                                              : $urandom_range(0, 23);
              p = load_req(psps_pkg::REQ_LIGHT, a, v);
            end
          endcase
        end
        send(p);
      end
      settle();
    end

    $display("Covered %0d pixel requests (%0d solved normals) and %0d table loads",
             pixels_sent, solved_seen, loads_sent);
    $display("over six light-count and shadow-threshold settings, with random stalls.");
    if (errors == 0) begin
      $display("tb_photometric_stereo_pixel_solve OK");
    end else begin
      $display("tb_photometric_stereo_pixel_solve NOT OK");
    end
    $finish;
  end

endmodule
